// ===== rtl/core/stts_pkg.sv =====
package stts_pkg;

  localparam int SIDE            = 16;
  localparam int PALETTE_ENTRIES = 16;
  localparam int ROM_ENTRIES     = 16;
  localparam int DEPTH           = SIDE * SIDE;
  localparam int ADDR_W          = $clog2(DEPTH);
  localparam int COORD_W         = 4;
  localparam int PIX_W           = 4;
  localparam int COLOR_W         = 16;
  localparam int OP_W            = 3;

  localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(SIDE - 1);

  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_FLIP_X = 3'd2;
  localparam logic [OP_W-1:0] OP_FLIP_Y = 3'd3;
  localparam logic [OP_W-1:0] OP_ROTATE = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  typedef struct packed {
    logic load;
    logic exec;
    logic read;
    logic emit;
  } stts_cmd_t;

  function automatic logic [COLOR_W-1:0] rgb565(input int r, input int g, input int b);
    logic [7:0] r8;
    logic [7:0] g8;
    logic [7:0] b8;
    r8 = 8'(r);
    g8 = 8'(g);
    b8 = 8'(b);
    return {r8[7:3], g8[7:2], b8[7:3]};
  endfunction

  localparam logic [COLOR_W-1:0] PALETTE [ROM_ENTRIES] = '{
    16'h0000,
    16'hFFFF,
    rgb565(74, 84, 96),
    rgb565(165, 175, 185),
    rgb565(225, 65, 75),
    rgb565(245, 135, 55),
    rgb565(250, 215, 70),
    rgb565(75, 195, 95),
    rgb565(45, 150, 125),
    rgb565(60, 185, 210),
    rgb565(70, 110, 225),
    rgb565(105, 75, 185),
    rgb565(205, 75, 180),
    rgb565(235, 125, 175),
    rgb565(120, 75, 45),
    rgb565(255, 235, 200)
  };

  function automatic logic [COLOR_W-1:0] color_of(input logic [PIX_W-1:0] idx);
    if (int'(idx) < PALETTE_ENTRIES && int'(idx) < ROM_ENTRIES) begin
      return PALETTE[idx];
    end
    return PALETTE[0];
  endfunction

endpackage

// ===== rtl/core/stts_ram.sv =====
module stts_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/stts_ctrl.sv =====
module stts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output stts_pkg::stts_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_OP   = 4'b0010,
    ST_RD   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_OP;
        end
      end
      ST_OP:   state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign cmd.load = start && (state_r == ST_IDLE);
  assign cmd.exec = (state_r == ST_OP);
  assign cmd.read = (state_r == ST_RD);
  assign cmd.emit = (state_r == ST_OUT);

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");

  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec) else $error("accepted item not executed");

  a_exec_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> ##1 cmd.emit) else $error("executed item not emitted");

endmodule

// ===== rtl/core/stts_dp.sv =====
module stts_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stts_pkg::stts_cmd_t          cmd,
  input  logic [stts_pkg::OP_W-1:0]    in_op,
  input  logic [stts_pkg::COORD_W-1:0] in_x_pos,
  input  logic [stts_pkg::COORD_W-1:0] in_y_pos,
  input  logic [stts_pkg::PIX_W-1:0]   in_pixel_value,
  output logic                         out_valid,
  output logic [stts_pkg::PIX_W-1:0]   out_pixel_index,
  output logic [stts_pkg::COLOR_W-1:0] out_pixel_color
);

  logic [stts_pkg::OP_W-1:0]    op_r;
  logic [stts_pkg::COORD_W-1:0] x_r;
  logic [stts_pkg::COORD_W-1:0] y_r;
  logic [stts_pkg::PIX_W-1:0]   val_r;

  // orientation of the stored tile relative to the logical one
  logic swap_r, fy_r, fx_r;
  logic swap_nxt, fy_nxt, fx_nxt;

  logic [stts_pkg::DEPTH-1:0] valid_r;
  logic [stts_pkg::DEPTH-1:0] valid_nxt;
  logic                       rd_valid_r;

  logic                         out_valid_r;
  logic [stts_pkg::PIX_W-1:0]   out_index_r;
  logic [stts_pkg::COLOR_W-1:0] out_color_r;

  logic [stts_pkg::COORD_W-1:0] row_sel, col_sel, py, px;
  logic [stts_pkg::ADDR_W-1:0]  addr;
  logic                         in_tile;
  logic                         wr_en;
  logic [stts_pkg::PIX_W-1:0]   ram_rdata;
  logic [stts_pkg::PIX_W-1:0]   idx;

  assign in_tile = (int'(x_r) < stts_pkg::SIDE) && (int'(y_r) < stts_pkg::SIDE);
  assign row_sel = swap_r ? x_r : y_r;
  assign col_sel = swap_r ? y_r : x_r;
  assign py      = fy_r ? (stts_pkg::LAST_COORD - row_sel) : row_sel;
  assign px      = fx_r ? (stts_pkg::LAST_COORD - col_sel) : col_sel;
  assign addr    = stts_pkg::ADDR_W'(int'(py) * stts_pkg::SIDE + int'(px));
  assign wr_en   = cmd.exec && (op_r == stts_pkg::OP_WRITE) && in_tile;

  always_comb begin
    swap_nxt = swap_r;
    fy_nxt   = fy_r;
    fx_nxt   = fx_r;
    if (cmd.exec) begin
      unique case (op_r)
        stts_pkg::OP_FLIP_X: begin
          if (swap_r) fy_nxt = !fy_r;
          else        fx_nxt = !fx_r;
        end
        stts_pkg::OP_FLIP_Y: begin
          if (swap_r) fx_nxt = !fx_r;
          else        fy_nxt = !fy_r;
        end
        stts_pkg::OP_ROTATE: begin
          swap_nxt = !swap_r;
          if (swap_r) fx_nxt = !fx_r;
          else        fy_nxt = !fy_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.exec && (op_r == stts_pkg::OP_CLEAR)) begin
      valid_nxt = '0;
    end else if (wr_en) begin
      valid_nxt[addr] = 1'b1;
    end
  end

  stts_ram #(
    .WIDTH (stts_pkg::PIX_W),
    .DEPTH (stts_pkg::DEPTH)
  ) u_tile_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr),
    .wdata (val_r),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign idx = (in_tile && rd_valid_r) ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r      <= 1'b0;
      fy_r        <= 1'b0;
      fx_r        <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      swap_r      <= swap_nxt;
      fy_r        <= fy_nxt;
      fx_r        <= fx_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      x_r   <= in_x_pos;
      y_r   <= in_y_pos;
      val_r <= in_pixel_value;
    end
    if (cmd.read) begin
      rd_valid_r <= valid_r[addr];
    end
    if (cmd.emit) begin
      out_index_r <= idx;
      out_color_r <= stts_pkg::color_of(idx);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_index_r;
  assign out_pixel_color = out_color_r;

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (op_r == stts_pkg::OP_CLEAR) |=> (valid_r == '0))
    else $error("clear left live entries");

  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(addr)]) else $error("written entry not marked");

  a_rotate_swaps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (op_r == stts_pkg::OP_ROTATE) |=> (swap_r != $past(swap_r)))
    else $error("rotation did not swap axes");

endmodule

// ===== rtl/core/sprite_tile_transform_store.sv =====
// channel   ports                                              transfer
// input     start, in_op, in_x_pos, in_y_pos, in_pixel_value   start && !busy
// result    out_valid, out_pixel_index, out_pixel_color        out_valid, one cycle
//
// Busy after the transfer through the op, RAM read and result states; the result
// strobes in the cycle after the result state, while the next item may start.
// The result is read from the single tile RAM, registered, after the op step.
// Flips and rotation only update a 3-bit orientation; clear drops the valid bits.
// rst_n synchronous: empty tile, identity orientation, no pending item.
// The receiver cannot stall; out_valid lasts exactly one cycle.
module sprite_tile_transform_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [stts_pkg::OP_W-1:0]    in_op,
  input  logic [stts_pkg::COORD_W-1:0] in_x_pos,
  input  logic [stts_pkg::COORD_W-1:0] in_y_pos,
  input  logic [stts_pkg::PIX_W-1:0]   in_pixel_value,
  output logic                         out_valid,
  output logic [stts_pkg::PIX_W-1:0]   out_pixel_index,
  output logic [stts_pkg::COLOR_W-1:0] out_pixel_color
);

  stts_pkg::stts_cmd_t cmd;

  stts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  stts_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_op),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_pixel_value  (in_pixel_value),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_pixel_color (out_pixel_color)
  );

endmodule
